// File: sv/rstu_pkg.sv
// Shared types and constants for the ranked score table unit.
// Used by rstu_cell and ranked_score_table_unit; depends on nothing.
package rstu_pkg;

  localparam int SCORE_W = 32;
  localparam int POS_W   = 5;
  localparam int RANK_W  = 6;

  // Command codes carried in the request
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [POS_W-1:0]   slot;
    logic [SCORE_W-1:0] score_ms;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [RANK_W-1:0]  rank;
    logic [SCORE_W-1:0] entry_score;
    logic               last;
  } out_res_t;

  // Operation a cell performs in one cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_MIN_RIGHT,
    CELL_MAX_LEFT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [SCORE_W-1:0] wr_data;
  } cell_ctrl_t;

endpackage

// File: sv/rstu_cell.sv
// One table entry of the ranked score table chain: holds a score and
// trades it with its neighbors. Depends on rstu_pkg.
module rstu_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rstu_pkg::cell_ctrl_t        ctrl_i,
  input  logic [rstu_pkg::SCORE_W-1:0] left_i,
  input  logic [rstu_pkg::SCORE_W-1:0] right_i,
  output logic [rstu_pkg::SCORE_W-1:0] val_o
);

  logic [rstu_pkg::SCORE_W-1:0] val_r;
  logic [rstu_pkg::SCORE_W-1:0] val_nxt;

  // Pick the next value: hold, write, compare-exchange half, or shift
  always_comb begin
    unique case (ctrl_i.op)
      rstu_pkg::CELL_HOLD:      val_nxt = val_r;
      rstu_pkg::CELL_WRITE:     val_nxt = ctrl_i.wr_data;
      rstu_pkg::CELL_MIN_RIGHT: val_nxt = (right_i < val_r) ? right_i : val_r;
      rstu_pkg::CELL_MAX_LEFT:  val_nxt = (left_i > val_r) ? left_i : val_r;
      rstu_pkg::CELL_SHIFT:     val_nxt = right_i;
      default:                  val_nxt = val_r;
    endcase
  end

  // Hold the entry; reset to the worst possible time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '1;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule

// File: sv/ranked_score_table_unit.sv
// Top level of the ranked score table: a chain of rstu_cell entries and
// the sequencer that writes, sorts and emits them. Depends on rstu_pkg.
//
//  channel  ports                    handshake
//  -------  -----------------------  ------------------------------------
//  request  start, busy, in_req      taken when start is high, busy low
//  result   out_valid, out_res       one entry per cycle, cannot stall
//
// Insert: write the last cell, run odd-even transposition across the chain
// in ST_SORT, then rotate the chain out through cell 0 in ST_EMIT. Dump
// skips the sort and goes straight to ST_EMIT; load and unused codes finish
// in ST_IDLE. Each result lags its emit cycle by one register. Reset sets
// every entry to all ones. Results are never held off, so nothing stalls.
module ranked_score_table_unit #(
  parameter int TABLE_SIZE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rstu_pkg::in_req_t  in_req,
  output logic               out_valid,
  output rstu_pkg::out_res_t out_res
);

  localparam int CNTW = $clog2(TABLE_SIZE);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(TABLE_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t                       state_r;
  logic [CNTW-1:0]              cnt_r;
  logic [rstu_pkg::RANK_W-1:0]  rank_r;
  logic [rstu_pkg::SCORE_W-1:0] prev_r;
  logic                         out_valid_r;
  rstu_pkg::out_res_t           out_res_r;

  logic                         accept;
  logic [rstu_pkg::RANK_W-1:0]  rank_nxt;
  logic [rstu_pkg::SCORE_W-1:0] val [TABLE_SIZE];
  rstu_pkg::cell_ctrl_t         ctrl [TABLE_SIZE];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Build the chain; the last cell's right neighbor is cell 0 so emit rotates
  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    localparam int   RIGHT = (g + 1) % TABLE_SIZE;
    localparam int   LEFT  = (g + TABLE_SIZE - 1) % TABLE_SIZE;
    localparam logic PAR   = 1'(g % 2);

    // Drive this cell's operation from the sequencer state
    always_comb begin
      ctrl[g].op      = rstu_pkg::CELL_HOLD;
      ctrl[g].wr_data = in_req.score_ms;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_req.cmd == rstu_pkg::CMD_INSERT && g == TABLE_SIZE - 1) begin
            ctrl[g].op = rstu_pkg::CELL_WRITE;
          end else if (accept && in_req.cmd == rstu_pkg::CMD_LOAD &&
                       in_req.slot == rstu_pkg::POS_W'(g)) begin
            ctrl[g].op = rstu_pkg::CELL_WRITE;
          end
        end
        ST_SORT: begin
          if (g + 1 < TABLE_SIZE && cnt_r[0] == PAR) begin
            ctrl[g].op = rstu_pkg::CELL_MIN_RIGHT;
          end else if (g >= 1 && cnt_r[0] != PAR) begin
            ctrl[g].op = rstu_pkg::CELL_MAX_LEFT;
          end
        end
        ST_EMIT: ctrl[g].op = rstu_pkg::CELL_SHIFT;
        default: ctrl[g].op = rstu_pkg::CELL_HOLD;
      endcase
    end

    rstu_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl_i  (ctrl[g]),
      .left_i  (val[LEFT]),
      .right_i (val[RIGHT]),
      .val_o   (val[g])
    );
  end

  // New rank at the first entry or when the score differs from the one before
  always_comb begin
    if (cnt_r == '0 || val[0] != prev_r) begin
      rank_nxt = rstu_pkg::RANK_W'(cnt_r) + rstu_pkg::RANK_W'(1);
    end else begin
      rank_nxt = rank_r;
    end
  end

  // Sequence the request and register each emitted entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept && in_req.cmd == rstu_pkg::CMD_INSERT) begin
            state_r <= ST_SORT;
          end else if (accept && in_req.cmd == rstu_pkg::CMD_DUMP) begin
            state_r <= ST_EMIT;
          end
        end
        ST_SORT: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end
        ST_EMIT: begin
          out_valid_r <= 1'b1;
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    // Payload needs no reset
    if (state_r == ST_EMIT) begin
      rank_r                <= rank_nxt;
      prev_r                <= val[0];
      out_res_r.position    <= rstu_pkg::POS_W'(cnt_r);
      out_res_r.rank        <= rank_nxt;
      out_res_r.entry_score <= val[0];
      out_res_r.last        <= (cnt_r == CNT_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: tb/sv/ranked_score_table_unit_tb.sv
// Self-checking testbench for ranked_score_table_unit: drives insert, load,
// dump and unused requests and checks every emitted entry against a model.
// Depends on rstu_pkg and ranked_score_table_unit.
module ranked_score_table_unit_tb;

  localparam int TABLE_SIZE = 8;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 142;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 8;
  localparam int REPORT_MAX = 10;

  // Expected-entry store and score table model
  class score_table_scoreboard;
    logic [rstu_pkg::SCORE_W-1:0] table_model[TABLE_SIZE];
    rstu_pkg::out_res_t pending_entries[$];
    int errors;

    function new();
      foreach (table_model[p]) table_model[p] = '1;
      errors = 0;
    endfunction

    // Queue one entry per table position, ranked from the previous entry
    function void push_table_entries();
      rstu_pkg::out_res_t e;
      int rank_now;
      rank_now = 1;
      for (int p = 0; p < TABLE_SIZE; p++) begin
        if (p == 0 || table_model[p] != table_model[p-1]) rank_now = p + 1;
        e.position = p[rstu_pkg::POS_W-1:0];
        e.rank = rank_now[rstu_pkg::RANK_W-1:0];
        e.entry_score = table_model[p];
        e.last = (p == TABLE_SIZE - 1);
        pending_entries.push_back(e);
      end
    endfunction

    // Update the table for an accepted request and queue its entries
    function void note_request(rstu_pkg::in_req_t req);
      logic [rstu_pkg::SCORE_W-1:0] v;
      int b;
      case (req.cmd)
        rstu_pkg::CMD_INSERT: begin
          table_model[TABLE_SIZE-1] = req.score_ms;
          for (int a = 1; a < TABLE_SIZE; a++) begin
            v = table_model[a];
            b = a;
            while (b > 0 && table_model[b-1] > v) begin
              table_model[b] = table_model[b-1];
              b--;
            end
            table_model[b] = v;
          end
          push_table_entries();
        end
        rstu_pkg::CMD_LOAD: begin
          if (req.slot < TABLE_SIZE) table_model[req.slot[IDX_W-1:0]] = req.score_ms;
        end
        rstu_pkg::CMD_DUMP: push_table_entries();
        default: ;
      endcase
    endfunction

    function void report(string what, rstu_pkg::out_res_t want, rstu_pkg::out_res_t got);
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("ERROR %s: expected pos %0d rank %0d score %h last %b", what,
                 want.position, want.rank, want.entry_score, want.last);
        $display("      got pos %0d rank %0d score %h last %b",
                 got.position, got.rank, got.entry_score, got.last);
      end
    endfunction

    // Compare one emitted entry with the oldest expectation
    function void check_entry(rstu_pkg::out_res_t got);
      rstu_pkg::out_res_t want;
      if (pending_entries.size() == 0) begin
        report("entry with nothing pending", '0, got);
        return;
      end
      want = pending_entries.pop_front();
      if (got.position !== want.position || got.rank !== want.rank ||
          got.entry_score !== want.entry_score || got.last !== want.last)
        report("entry mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rstu_pkg::in_req_t in_req;
  logic out_valid;
  rstu_pkg::out_res_t out_res;

  score_table_scoreboard sb;
  bit no_idle;
  int quiet_cycles;
  int counted;

  ranked_score_table_unit #(.TABLE_SIZE(TABLE_SIZE)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check results, note accepted requests, and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_entry(out_res);
      if (start && !busy) sb.note_request(in_req);
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no activity for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Present one request after a random gap and hold it until taken
  task automatic send_request(input logic [1:0] op,
                              input logic [rstu_pkg::POS_W-1:0] slot_idx,
                              input logic [rstu_pkg::SCORE_W-1:0] score);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_req.cmd = op;
    in_req.slot = slot_idx;
    in_req.score_ms = score;
    do @(posedge clk); while (busy);
  endtask

  // Favor extremes and small tie-prone values over plain random scores
  function automatic logic [rstu_pkg::SCORE_W-1:0] draw_score();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 15) * 1000;
      default: return $urandom();
    endcase
  endfunction

  // Load every slot as when a saved table is restored
  task automatic restore_table();
    for (int p = 0; p < TABLE_SIZE; p++)
      send_request(rstu_pkg::CMD_LOAD, p[rstu_pkg::POS_W-1:0], draw_score());
  endtask

  initial begin
    sb = new();
    start = 1'b0;
    in_req = '0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    counted = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset table, extremes, ties, unsorted dump, ignored requests
    send_request(rstu_pkg::CMD_DUMP, 5'd31, 32'hFFFF_FFFF);
    send_request(rstu_pkg::CMD_INSERT, 5'd0, 32'h0000_0000);
    send_request(rstu_pkg::CMD_INSERT, 5'd31, 32'hFFFF_FFFF);
    send_request(rstu_pkg::CMD_INSERT, 5'd0, 32'd1000);
    send_request(rstu_pkg::CMD_INSERT, 5'd0, 32'd1000);
    send_request(rstu_pkg::CMD_DUMP, 5'd0, 32'h0);
    send_request(rstu_pkg::CMD_LOAD, 5'd0, 32'hFFFF_FFFF);
    send_request(rstu_pkg::CMD_LOAD, 5'd7, 32'h0000_0000);
    send_request(rstu_pkg::CMD_LOAD, 5'd3, 32'd5000);
    send_request(rstu_pkg::CMD_DUMP, 5'd0, 32'h0);
    send_request(rstu_pkg::CMD_LOAD, 5'd8, 32'h1234_5678);
    send_request(rstu_pkg::CMD_LOAD, 5'd31, 32'h0);
    send_request(rstu_pkg::CMD_LOAD, 5'd16, 32'h0);
    send_request(CMD_UNUSED, 5'd2, 32'h0);
    send_request(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
    send_request(rstu_pkg::CMD_DUMP, 5'd0, 32'h0);
    send_request(rstu_pkg::CMD_INSERT, 5'd21, 32'h5555_5555);
    send_request(rstu_pkg::CMD_INSERT, 5'd10, 32'hAAAA_AAAA);
    for (int p = 0; p < TABLE_SIZE; p++)
      send_request(rstu_pkg::CMD_LOAD, p[rstu_pkg::POS_W-1:0], 32'd7000);
    send_request(rstu_pkg::CMD_DUMP, 5'd0, 32'h0);
    send_request(rstu_pkg::CMD_INSERT, 5'd0, 32'd7000);

    // Random: mostly restore/insert/dump traffic, some ignored requests
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) no_idle = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_request(rstu_pkg::CMD_INSERT, 5'($urandom_range(0, 31)), draw_score());
          counted++;
        end
        4: begin
          restore_table();
          send_request(rstu_pkg::CMD_DUMP, 5'($urandom_range(0, 31)), $urandom());
          counted += TABLE_SIZE + 1;
        end
        5, 6: begin
          send_request(rstu_pkg::CMD_DUMP, 5'($urandom_range(0, 31)), $urandom());
          counted++;
        end
        7: begin
          send_request(rstu_pkg::CMD_LOAD, 5'($urandom_range(0, TABLE_SIZE - 1)),
                       draw_score());
          counted++;
        end
        8: begin
          send_request(rstu_pkg::CMD_LOAD, 5'($urandom_range(TABLE_SIZE, 31)),
                       draw_score());
          counted++;
        end
        default: begin
          send_request(CMD_UNUSED, 5'($urandom_range(0, 31)), $urandom());
          counted++;
        end
      endcase
    end
    @(negedge clk);
    start = 1'b0;

    // Drain outstanding entries, then watch for stray ones
    while (sb.pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_entries.size() != 0) begin
      sb.errors++;
      $display("ERROR: %0d expected entries never arrived", sb.pending_entries.size());
    end
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: ranked_score_table_unit.f
sv/rstu_pkg.sv
sv/rstu_cell.sv
sv/ranked_score_table_unit.sv
tb/sv/ranked_score_table_unit_tb.sv
